@@ sv/spr_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spr_pkg;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned RANK_BITS  = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned IN_RANK_W  = 8;
  localparam int unsigned OUT_RANK_W = 8;
  localparam int unsigned OCC_W      = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spr_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spr_status_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_ENQ,
    ACT_DEQ
  } spr_act_e;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [RANK_BITS-1:0] rank;
  } spr_entry_t;

  // Broadcast to every cell in the row for the transaction in hand.
  typedef struct packed {
    spr_act_e   act;
    spr_entry_t item;
  } spr_ctrl_t;

endpackage

@@ sv/spr_cell.sv @@
// One compare-and-shift cell of the sorted row.
module spr_cell import spr_pkg::*; (
  input  logic       clk_i,
  input  spr_ctrl_t  ctrl_i,
  input  logic       occupied_i,
  input  logic       left_lt_i,
  input  spr_entry_t left_entry_i,
  input  spr_entry_t right_entry_i,
  output spr_entry_t entry_o,
  output logic       lt_o
);

  spr_entry_t entry_q, entry_d;

  // The held entry ranks strictly below the new item, so it stays in place.
  assign lt_o = occupied_i && (entry_q.rank < ctrl_i.item.rank);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.act)
      ACT_ENQ: begin
        if (!lt_o) begin
          entry_d = left_lt_i ? ctrl_i.item : left_entry_i;
        end
      end
      ACT_DEQ: entry_d = right_entry_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a row of compare-and-shift cells.
// The result of a transaction is shown in the cycle after it is accepted.
// Throughput: one transaction per cycle; busy_o never rises, because every cell
// inserts or shifts as it is clocked and the row settles at each clock edge.
// Reset empties the queue by clearing the entry count; slot contents are left as
// they are. There is no result back-pressure: the receiver must take each result.
module sorted_priority_queue import spr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    opcode_i,
  input  logic signed [VALUE_W-1:0] item_value_i,
  input  logic [IN_RANK_W-1:0]    item_rank_i,
  output logic                    done_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic [OUT_RANK_W-1:0]   out_rank_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  // The row handles every transaction as it comes, so the block is never busy.
  assign busy_o = 1'b0;

  logic      accept;
  logic      full, empty;
  spr_ctrl_t ctrl;

  logic [CNT_W-1:0] count_q, count_d;

  spr_entry_t       cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_lt;
  logic [DEPTH-1:0] occupied;

  // Result register.
  logic                 done_q;
  spr_status_e          status_q, status_d;
  logic [VALUE_W-1:0]   value_q, value_d;
  logic [RANK_BITS-1:0] rank_q, rank_d;
  logic [CNT_W-1:0]     occ_q;

  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Work out the action of the row and the result of this transaction.
  // A refused transaction leaves the row and the count untouched.
  always_comb begin
    ctrl.item.value = item_value_i;
    ctrl.item.rank  = RANK_BITS'(item_rank_i);
    ctrl.act        = ACT_HOLD;
    count_d         = count_q;
    status_d        = ST_OK;
    value_d         = '0;
    rank_d          = '0;
    if (accept) begin
      unique case (spr_op_e'(opcode_i))
        OP_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.act = ACT_ENQ;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            // The head cell always holds the lowest rank.
            ctrl.act = ACT_DEQ;
            count_d  = count_q - CNT_W'(1);
            value_d  = cell_entry[0].value;
            rank_d   = cell_entry[0].rank;
          end
        end
        default: ctrl.act = ACT_HOLD;
      endcase
    end
  end

  // The row of cells. Each cell looks only at its neighbours: on an insertion
  // a cell whose entry does not rank below the new item either takes the item,
  // when its left neighbour keeps its place, or takes the left neighbour's
  // entry. Because the row is sorted, the cells that keep their place form a
  // prefix, so equal ranks end up behind the new item. On a removal every cell
  // takes its right neighbour's entry, and the last cell keeps its own.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic       left_lt;
    spr_entry_t left_entry;
    spr_entry_t right_entry;

    assign occupied[g] = (count_q > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = cell_entry[g];
    end else begin : g_body
      assign left_lt    = cell_lt[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    spr_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied[g]),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[g]),
      .lt_o          (cell_lt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      rank_q   <= rank_d;
      occ_q    <= count_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_value_o = value_q;
  assign out_rank_o  = OUT_RANK_W'(rank_q);
  assign occupancy_o = OCC_W'(occ_q);

endmodule

@@ sv/spr_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
module spr_checker import spr_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      opcode_i,
  input logic                      done_o,
  input logic [STATUS_W-1:0]       status_o,
  input logic signed [VALUE_W-1:0] out_value_o,
  input logic [OUT_RANK_W-1:0]     out_rank_o,
  input logic [OCC_W-1:0]          occupancy_o
);

  // Each accepted transaction gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without a transaction");

  // A refused insertion can only happen with the queue holding DEPTH entries.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |->
      (occupancy_o == OCC_W'(DEPTH) && $past(opcode_i) == OP_ENQ))
    else $error("full status with wrong occupancy or operation");

  // A refused removal leaves an empty queue and returns nothing.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |->
      (occupancy_o == '0 && out_value_o == '0 && out_rank_o == '0))
    else $error("empty status with data or occupancy");

endmodule

bind sorted_priority_queue spr_checker u_spr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .opcode_i    (opcode_i),
  .done_o      (done_o),
  .status_o    (status_o),
  .out_value_o (out_value_o),
  .out_rank_o  (out_rank_o),
  .occupancy_o (occupancy_o)
);

@@ verif/sorted_priority_queue_tb.sv @@
// Self-checking testbench for the sorted priority queue: random and directed transactions.
`timescale 1ns / 100ps

// One result as the queue should report it.
typedef struct packed {
  spr_pkg::spr_status_e                status;
  logic signed [spr_pkg::VALUE_W-1:0]  value;
  logic [spr_pkg::OUT_RANK_W-1:0]      rank;
  logic [spr_pkg::OCC_W-1:0]           occupancy;
} pq_outcome_t;

// Mirror of the queue contents, kept in rank order, with the outcomes still owed by the block.
class queue_mirror;
  logic signed [spr_pkg::VALUE_W-1:0] slot_val[spr_pkg::DEPTH];
  logic [spr_pkg::RANK_BITS-1:0]      slot_rk[spr_pkg::DEPTH];
  int unsigned held;
  pq_outcome_t owed[$];
  int unsigned failures, stored, removed, refused_full, refused_empty, peak;

  function int unsigned pending();
    return owed.size();
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("Mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // Applies one accepted transaction to the mirror and queues the outcome it should give.
  function void apply_transaction(spr_pkg::spr_op_e op,
                                  logic signed [spr_pkg::VALUE_W-1:0] val,
                                  logic [spr_pkg::IN_RANK_W-1:0] rank_in);
    pq_outcome_t res;
    logic [spr_pkg::RANK_BITS-1:0] rk;
    int unsigned pos;
    res = '0;
    res.status = spr_pkg::ST_OK;
    rk = rank_in[spr_pkg::RANK_BITS-1:0];
    if (op == spr_pkg::OP_ENQ) begin
      if (held >= spr_pkg::DEPTH) begin
        res.status = spr_pkg::ST_FULL;
        refused_full++;
      end else begin
        // The new entry goes ahead of every entry of equal rank.
        pos = 0;
        while (pos < held && slot_rk[pos] < rk) pos++;
        for (int unsigned i = held; i > pos; i--) begin
          slot_val[i] = slot_val[i-1];
          slot_rk[i]  = slot_rk[i-1];
        end
        slot_val[pos] = val;
        slot_rk[pos]  = rk;
        held++;
        stored++;
      end
    end else if (held == 0) begin
      res.status = spr_pkg::ST_EMPTY;
      refused_empty++;
    end else begin
      res.value = slot_val[0];
      res.rank  = slot_rk[0];
      for (int unsigned i = 1; i < held; i++) begin
        slot_val[i-1] = slot_val[i];
        slot_rk[i-1]  = slot_rk[i];
      end
      held--;
      removed++;
    end
    res.occupancy = spr_pkg::OCC_W'(held);
    if (held > peak) peak = held;
    owed.push_back(res);
  endfunction

  // Compares one result from the block with the oldest outcome owed.
  function void compare_result(logic [spr_pkg::STATUS_W-1:0] status,
                               logic signed [spr_pkg::VALUE_W-1:0] value,
                               logic [spr_pkg::OUT_RANK_W-1:0] rank,
                               logic [spr_pkg::OCC_W-1:0] occupancy);
    pq_outcome_t want;
    if (owed.size() == 0) begin
      note_failure({$sformatf("result with nothing outstanding: status %0d value %0d ",
                              status, value),
                    $sformatf("rank %0d occ %0d", rank, occupancy)});
      return;
    end
    want = owed.pop_front();
    if (status !== want.status || value !== want.value || rank !== want.rank ||
        occupancy !== want.occupancy) begin
      note_failure({$sformatf("expected status %0d value %0d rank %0d occ %0d, ",
                              want.status, want.value, want.rank, want.occupancy),
                    $sformatf("got status %0d value %0d rank %0d occ %0d",
                              status, value, rank, occupancy)});
    end
  endfunction
endclass

module sorted_priority_queue_tb;
  import spr_pkg::*;

  // Number of random transactions after the directed opening, and how many of the last ones
  // are sent back to back with no gaps.
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned QUIET_TAIL   = 80;
  // Cycle budget for the whole run; this leaves a wide margin over a correct run.
  localparam int unsigned CYCLE_LIMIT  = 50000;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       start_i      = 1'b0;
  logic                       opcode_i     = 1'b0;
  logic signed [VALUE_W-1:0]  item_value_i = '0;
  logic [IN_RANK_W-1:0]       item_rank_i  = '0;
  logic                       busy_o;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [VALUE_W-1:0]  out_value_o;
  logic [OUT_RANK_W-1:0]      out_rank_o;
  logic [OCC_W-1:0]           occupancy_o;

  int unsigned cycle_count = 0;
  queue_mirror sb = new;

  sorted_priority_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .item_value_i(item_value_i),
    .item_rank_i (item_rank_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_rank_o  (out_rank_o),
    .occupancy_o (occupancy_o)
  );

  // 12 ns clock: six nanoseconds low, six high.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog. Should the block stop answering, the run ends here rather than hanging.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, so it sees the values that were settled
  // just before the edge, both for the testbench's own inputs and for the block's registered
  // outputs. The result is checked before the transaction of the same edge is noted; with a
  // first-in first-out store of outcomes the order makes no difference to the pairing.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.compare_result(status_o, out_value_o, out_rank_o, occupancy_o);
      end
      if (start_i && !busy_o) begin
        sb.apply_transaction(spr_op_e'(opcode_i), item_value_i, item_rank_i);
      end
    end
  end

  // Presents one transaction and returns at the edge where the block takes it. The caller is at
  // a rising edge, so start_i is raised for the coming cycle and held until busy_o lets it in.
  task automatic send_item(input spr_op_e op, input logic signed [VALUE_W-1:0] val,
                           input logic [IN_RANK_W-1:0] rank);
    start_i      <= 1'b1;
    opcode_i     <= op;
    item_value_i <= val;
    item_rank_i  <= rank;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every owed result has come back. The first edge lets the
  // monitor note the transaction that was accepted at the edge where this is called.
  task automatic await_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned mode_left;
    int unsigned fill_pct;
    bit gappy;
    spr_op_e op;
    logic signed [VALUE_W-1:0] val;
    logic [IN_RANK_W-1:0] rank;

    mode_left = 0;
    fill_pct  = 50;
    gappy     = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. A dequeue on the empty queue must be refused; its value and rank
    // carry junk to show that they are ignored.
    send_item(OP_DEQ, 32'sh5a5a_a5a5, 8'ha5);
    // Fill the queue with the extreme values and ranks, including three entries that share a
    // rank: among those the newest must come out first.
    send_item(OP_ENQ, 32'sh7fff_ffff, 8'd255);
    send_item(OP_ENQ, 32'sh8000_0000, 8'd0);
    send_item(OP_ENQ, 32'sh0000_0000, 8'd128);
    send_item(OP_ENQ, -32'sd1,        8'd255);
    send_item(OP_ENQ, 32'sd1,         8'd7);
    send_item(OP_ENQ, 32'sd2,         8'd7);
    send_item(OP_ENQ, 32'sd3,         8'd7);
    send_item(OP_ENQ, 32'sh5555_aaaa, 8'd0);
    // The queue now holds DEPTH entries, so this enqueue must be refused as full.
    send_item(OP_ENQ, 32'sd123,       8'd1);
    // Empty it completely, then once more to see the empty refusal again.
    repeat (DEPTH + 1) send_item(OP_DEQ, '1, '1);

    // Hold off until the directed part has fully drained.
    await_drain();

    // Random part. It runs in bursts, each biased towards filling, draining or a balance, so
    // the occupancy sweeps the whole range and both refusals come up often. Ranks favour a
    // narrow band to make ties common.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 30);
        case ($urandom_range(0, 2))
          0: fill_pct = 75;
          1: fill_pct = 25;
          default: fill_pct = 50;
        endcase
        gappy = 1'($urandom_range(0, 1));
      end
      mode_left--;

      if (n == RANDOM_ITEMS / 2) begin
        await_drain();
      end else if (gappy && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end

      op = ($urandom_range(0, 99) < fill_pct) ? OP_ENQ : OP_DEQ;
      case ($urandom_range(0, 11))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = '0;
        3: val = '1;
        default: val = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rank = IN_RANK_W'($urandom_range(0, 3));
        4: rank = '0;
        5: rank = '1;
        default: rank = IN_RANK_W'($urandom_range(0, 255));
      endcase
      send_item(op, val, rank);
    end

    // Let the last results come back, then wait on to catch any stray strobe.
    await_drain();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d transactions: %0d stored, %0d removed, refused %0d full, %0d empty.",
             sb.stored + sb.removed + sb.refused_full + sb.refused_empty,
             sb.stored, sb.removed, sb.refused_full, sb.refused_empty);
    $display("Occupancy reached %0d of %0d; %0d mismatches seen.", sb.peak, DEPTH, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
sv/spr_pkg.sv
sv/spr_cell.sv
sv/sorted_priority_queue.sv
sv/spr_checker.sv
verif/sorted_priority_queue_tb.sv
